[hw/rtl/rws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics package
// Shared types, constants and codes for the window statistics block.
// ----------------------------------------------------------------------------
package rws_pkg;

   // Sample counter width; sum holds up to 2**COUNT_BITS - 1 samples of 12 bits each
   localparam int COUNT_BITS = 24;
   localparam int SUM_BITS   = COUNT_BITS + 12;
   localparam int MILLE_BITS = COUNT_BITS + 10;

   // Shared restoring divider: numerator width and quotient bits per run
   localparam int DIV_BITS   = SUM_BITS + 2;
   localparam int QUO_BITS   = 12;
   localparam int QCNT_BITS  = $clog2(QUO_BITS);

   // Command queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int LVL_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [15:0] WIN_MIN     = 16'd100;
   localparam logic [15:0] WIN_MAX     = 16'd60000;
   localparam logic [15:0] WINEL_MAX   = 16'hFFFF;
   localparam logic [16:0] DUR_MIN     = 17'd1;
   localparam logic [16:0] DUR_MAX     = 17'd86400;
   localparam logic [26:0] TOTAL_MAX   = 27'h7FF_FFFF;
   localparam logic [9:0]  MS_PER_S    = 10'd1000;
   localparam logic [9:0]  PERMILLE    = 10'd1000;

   localparam logic signed [11:0] SAMPLE_LO  = -12'sd2000;
   localparam logic signed [11:0] SAMPLE_HI  = 12'sd2000;
   localparam logic signed [11:0] THR_RESET  = -12'sd1000;
   localparam logic signed [13:0] THR_SAT_HI = 14'sd2047;
   localparam logic signed [13:0] THR_SAT_LO = -14'sd2048;

   // Register reset values
   localparam logic [15:0]        WINDOW_MS_RST   = 16'd1000;
   localparam logic [16:0]        DURATION_S_RST  = 17'd60;
   localparam logic [8:0]         THR_DELTA_RST   = 9'd100;
   localparam logic signed [11:0] FIRST_THR_RST   = -12'sd1000;

   localparam int CSR_DATA_BITS = 17;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_MS       = 2'd0,
      CSR_DURATION_S      = 2'd1,
      CSR_THRESHOLD_DELTA = 2'd2,
      CSR_FIRST_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_DONE   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_AVG,
      ST_DIV_DUTY,
      ST_REPORT,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      act_type           action;
      logic signed [11:0] rssi;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [23:0]        sample_count;
      logic signed [11:0] average;
      logic signed [11:0] maximum;
      logic signed [11:0] minimum;
      logic [23:0]        over_count;
      logic [9:0]         duty_permille;
      logic signed [11:0] threshold_used;
      logic               last;
   } rsp_type;

   // Configuration as the back end sees it: clamped, limit precomputed
   typedef struct packed {
      logic [15:0]        window_ms;
      logic [26:0]        dur_limit;
      logic [8:0]         threshold_delta;
      logic signed [11:0] first_threshold;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] numer;
      logic [DIV_BITS-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/rws_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics divider
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
module rws_div
   import rws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_BITS-1:0]  rem_ff,  rem_in;
   logic [DIV_BITS-1:0]  dsh_ff,  dsh_in;
   logic [QUO_BITS-1:0]  quo_ff,  quo_in;
   logic [QCNT_BITS-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.numer;
         dsh_in  = div_req.denom << (QUO_BITS - 1);
         quo_in  = '0;
         cnt_in  = QCNT_BITS'(QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Subtract when the shifted divisor fits, shift it down
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[hw/rtl/rws_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics front end
// Accepts items, drops unknown actions, queues commands for the back end.
// ----------------------------------------------------------------------------
module rws_front
   import rws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   output req_type cmd_data,
   input  logic    cmd_pop
);

   req_type             entry_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_BITS-1:0] level_ff,  level_in;
   logic                push;
   logic                pop;

   assign req_ready = (level_ff != LVL_BITS'(FIFO_DEPTH));
   assign push      = req_valid && req_ready && (req_data.action != ACT_NONE);
   assign cmd_valid = (level_ff != '0);
   assign cmd_data  = entry_ff[rd_ptr_ff];
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

[hw/rtl/rws_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics back end
// Holds the window state, runs commands and forms the result items.
// ----------------------------------------------------------------------------
module rws_back
   import rws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  req_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   back_state_type state_ff, state_in;

   logic                       active_ff,   active_in;
   logic [COUNT_BITS-1:0]      count_ff,    count_in;
   logic signed [SUM_BITS-1:0] sum_ff,      sum_in;
   logic signed [11:0]         max_ff,      max_in;
   logic signed [11:0]         min_ff,      min_in;
   logic [COUNT_BITS-1:0]      over_ff,     over_in;
   logic signed [11:0]         thr_ff,      thr_in;
   logic [15:0]                win_el_ff,   win_el_in;
   logic [26:0]                total_ff,    total_in;
   logic                       done_pend_ff, done_pend_in;
   logic signed [11:0]         avg_ff,      avg_in;
   logic [9:0]                 duty_ff,     duty_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                       out_free;
   logic signed [SUM_BITS-1:0] sample_ext;
   logic [SUM_BITS-1:0]        sum_mag;
   logic [MILLE_BITS-1:0]      over_mille;
   logic signed [13:0]         thr_sum;
   logic signed [11:0]         thr_next;
   logic [15:0]                win_el_step;
   logic [26:0]                total_step;
   logic [QUO_BITS-1:0]        avg_neg;

   rws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign sample_ext  = SUM_BITS'(cmd_data.rssi);
   assign sum_mag     = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign over_mille  = MILLE_BITS'(over_ff) * MILLE_BITS'(PERMILLE);
   assign thr_sum     = 14'(min_ff) + $signed({5'd0, cfg.threshold_delta});
   assign thr_next    = (thr_sum > THR_SAT_HI) ? 12'(THR_SAT_HI) :
                        (thr_sum < THR_SAT_LO) ? 12'(THR_SAT_LO) : 12'(thr_sum);
   assign win_el_step = (win_el_ff == WINEL_MAX) ? win_el_ff : win_el_ff + 1'b1;
   assign total_step  = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 1'b1;
   assign avg_neg     = -div_rsp.quotient;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      over_in      = over_ff;
      thr_in       = thr_ff;
      win_el_in    = win_el_ff;
      total_in     = total_ff;
      done_pend_in = done_pend_ff;
      avg_in       = avg_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_data.action)
                  ACT_START: begin
                     active_in = 1'b1;
                     count_in  = '0;
                     sum_in    = '0;
                     over_in   = '0;
                     max_in    = SAMPLE_LO;
                     min_in    = SAMPLE_HI;
                     win_el_in = '0;
                     thr_in    = cfg.first_threshold;
                     total_in  = '0;
                  end
                  ACT_SAMPLE: begin
                     // Drop the sample while idle or once the count has saturated
                     if (active_ff && (count_ff != COUNT_MAX)) begin
                        if (count_ff == '0) begin
                           max_in = cmd_data.rssi;
                           min_in = cmd_data.rssi;
                        end else begin
                           if (cmd_data.rssi > max_ff) max_in = cmd_data.rssi;
                           if (cmd_data.rssi < min_ff) min_in = cmd_data.rssi;
                        end
                        count_in = count_ff + 1'b1;
                        sum_in   = sum_ff + sample_ext;
                        if (cmd_data.rssi > thr_ff) over_in = over_ff + 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (active_ff) begin
                        win_el_in    = win_el_step;
                        total_in     = total_step;
                        done_pend_in = (total_step >= cfg.dur_limit);
                        if ((win_el_step >= cfg.window_ms) && (count_ff != '0)) begin
                           // Rounded average: (2|sum| + n) / 2n
                           div_req.start = 1'b1;
                           div_req.numer = (DIV_BITS'(sum_mag) << 1) + DIV_BITS'(count_ff);
                           div_req.denom = DIV_BITS'(count_ff) << 1;
                           state_in      = ST_DIV_AVG;
                        end else if (total_step >= cfg.dur_limit) begin
                           state_in = ST_DONE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_AVG: begin
            if (div_rsp.done) begin
               avg_in = sum_ff[SUM_BITS-1] ? $signed(avg_neg) : $signed(div_rsp.quotient);
               div_req.start = 1'b1;
               div_req.numer = DIV_BITS'(over_mille);
               div_req.denom = DIV_BITS'(count_ff);
               state_in      = ST_DIV_DUTY;
            end
         end
         ST_DIV_DUTY: begin
            if (div_rsp.done) begin
               duty_in  = 10'(div_rsp.quotient);
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.kind           = KIND_REPORT;
               rsp_data_in.sample_count   = 24'(count_ff);
               rsp_data_in.average        = avg_ff;
               rsp_data_in.maximum        = max_ff;
               rsp_data_in.minimum        = min_ff;
               rsp_data_in.over_count     = 24'(over_ff);
               rsp_data_in.duty_permille  = duty_ff;
               rsp_data_in.threshold_used = thr_ff;
               rsp_data_in.last           = !done_pend_ff;
               // Adapt the threshold and open a fresh window
               thr_in    = thr_next;
               count_in  = '0;
               sum_in    = '0;
               over_in   = '0;
               max_in    = SAMPLE_LO;
               min_in    = SAMPLE_HI;
               win_el_in = '0;
               state_in  = done_pend_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in       = '0;
               rsp_data_in.kind  = KIND_DONE;
               rsp_data_in.last  = 1'b1;
               active_in         = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         max_ff       <= SAMPLE_LO;
         min_ff       <= SAMPLE_HI;
         over_ff      <= '0;
         thr_ff       <= THR_RESET;
         win_el_ff    <= '0;
         total_ff     <= '0;
         done_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         over_ff      <= over_in;
         thr_ff       <= thr_in;
         win_el_ff    <= win_el_in;
         total_ff     <= total_in;
         done_pend_ff <= done_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_ff      <= avg_in;
      duty_ff     <= duty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/rssi_window_statistics_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics
// Windowed count, mean, extremes and burst duty with an adaptive threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: action (start, sample, millisecond tick) and rssi.
//   rsp_* returns window reports and the dwell-finished item; last marks the
//   final item caused by one input item (a tick may cause a report and done).
//   csr_* writes one register per handshake (window_ms, duration_s,
//   threshold_delta, first_threshold); write only while the block is idle.
// Command flow:
//   Items pass a two-entry command queue into the back end, which runs one
//   command per cycle while idle; starts, samples and quiet ticks are handled
//   there directly. A tick that closes a window runs the shared restoring
//   divider twice (average, then duty); no further command is taken until
//   its report, then done if the dwell ends, enter the output register.
// Reset:
//   Synchronous, active high: control and configuration registers take their
//   default values, the block is idle and the queue is empty.
// Stalls:
//   A result waits in the output register while rsp_ready is low; the back
//   end holds, the queue fills and req_ready drops when it is full.
// ----------------------------------------------------------------------------
module rssi_window_statistics_top
   import rws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // Register file, as written
   logic [15:0]        window_ms_ff;
   logic [16:0]        duration_s_ff;
   logic [8:0]         thr_delta_ff;
   logic signed [11:0] first_thr_ff;

   // Clamped values and dwell limit in ms, refreshed every cycle
   cfg_type            cfg_ff, cfg_in;
   logic [16:0]        dur_clamp;

   logic               cmd_valid;
   req_type            cmd_data;
   logic               cmd_pop;

   // Always take register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff  <= WINDOW_MS_RST;
         duration_s_ff <= DURATION_S_RST;
         thr_delta_ff  <= THR_DELTA_RST;
         first_thr_ff  <= FIRST_THR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_MS:       window_ms_ff  <= csr_wdata[15:0];
            CSR_DURATION_S:      duration_s_ff <= csr_wdata[16:0];
            CSR_THRESHOLD_DELTA: thr_delta_ff  <= csr_wdata[8:0];
            CSR_FIRST_THRESHOLD: first_thr_ff  <= $signed(csr_wdata[11:0]);
            default: begin
            end
         endcase
      end
   end

   // Clamp the window and dwell length to their legal ranges
   assign dur_clamp = (duration_s_ff < DUR_MIN) ? DUR_MIN :
                      (duration_s_ff > DUR_MAX) ? DUR_MAX : duration_s_ff;

   always_comb begin
      cfg_in.window_ms       = (window_ms_ff < WIN_MIN) ? WIN_MIN :
                               (window_ms_ff > WIN_MAX) ? WIN_MAX : window_ms_ff;
      cfg_in.dur_limit       = 27'(dur_clamp) * 27'(MS_PER_S);
      cfg_in.threshold_delta = thr_delta_ff;
      cfg_in.first_threshold = first_thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms       <= WINDOW_MS_RST;
         cfg_ff.dur_limit       <= 27'(DURATION_S_RST) * 27'(MS_PER_S);
         cfg_ff.threshold_delta <= THR_DELTA_RST;
         cfg_ff.first_threshold <= FIRST_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, drop unknown actions, queue
   rws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // Back: window state, divider, output register
   rws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A done item is always the final one and carries no statistics
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_DONE) |->
         rsp_data.last && (rsp_data.sample_count == '0) && (rsp_data.over_count == '0))
      else $error("done item malformed");

   // A report never shows more bursts than samples, nor duty above 1000
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_REPORT) |->
         (rsp_data.duty_permille <= PERMILLE) &&
         (rsp_data.over_count <= rsp_data.sample_count))
      else $error("report statistics inconsistent");

   // A report covers at least one sample and its extremes are ordered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_REPORT) |->
         (rsp_data.sample_count != '0) && (rsp_data.minimum <= rsp_data.maximum))
      else $error("report window empty or extremes swapped");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI window statistics testbench
// Drives dwell starts, RSSI samples and millisecond ticks into the block and
// checks every window report and dwell-finished item against a behavioral
// predictor of the window statistics, under several idling and stall
// patterns and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
   import rws_pkg::*;

   // Cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles to let the back end settle after the last expected item
   localparam int SETTLE_CYCLES  = 64;
   // Mismatch lines printed before further ones are only counted
   localparam int PRINT_LIMIT    = 100;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Idling pattern of the current phase, in percent per cycle
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int mismatches   = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int band_center  = 0;

   // Register copies as the predictor sees them
   logic [15:0]        cfg_window_ms  = WINDOW_MS_RST;
   logic [16:0]        cfg_duration_s = DURATION_S_RST;
   logic [8:0]         cfg_delta      = THR_DELTA_RST;
   logic signed [11:0] cfg_first_thr  = FIRST_THR_RST;

   // Window and dwell state of the predictor
   logic               dwell_active     = 1'b0;
   logic [23:0]        win_count        = '0;
   logic signed [35:0] win_sum          = '0;
   logic signed [11:0] win_max          = SAMPLE_LO;
   logic signed [11:0] win_min          = SAMPLE_HI;
   logic [23:0]        win_over         = '0;
   logic signed [11:0] burst_thr        = THR_RESET;
   logic [15:0]        win_ms_elapsed   = '0;
   logic [26:0]        dwell_ms_elapsed = '0;

   // Window reports and done items predicted but not yet seen, oldest first
   rsp_type pending_reports[$];
   rsp_type oldest_report;

   rssi_window_statistics_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Clear the window accumulators and restart the window timer
   function automatic void open_window();
      win_count      = '0;
      win_sum        = '0;
      win_over       = '0;
      win_max        = SAMPLE_LO;
      win_min        = SAMPLE_HI;
      win_ms_elapsed = '0;
   endfunction

   // Advance the predictor by one accepted item and queue what it causes
   function automatic void compute_window_results(req_type item);
      rsp_type            rep;
      rsp_type            fin;
      logic signed [11:0] smp;
      logic [15:0]        win_len;
      logic [16:0]        dur_len;
      longint             cnt;
      longint             mag;
      longint             quo;
      longint             avg;
      longint             duty;
      longint             next_thr;
      bit                 closing;
      bit                 ending;
      rep = '0;
      fin = '0;
      smp = item.rssi;
      case (item.action)
      ACT_START: begin
         dwell_active     = 1'b1;
         open_window();
         burst_thr        = cfg_first_thr;
         dwell_ms_elapsed = '0;
      end
      ACT_SAMPLE: begin
         // drop samples while idle or once the count has saturated
         if (dwell_active && win_count != COUNT_MAX) begin
            if (win_count == 0) begin
               win_max = smp;
               win_min = smp;
            end else begin
               if (smp > win_max) win_max = smp;
               if (smp < win_min) win_min = smp;
            end
            win_count = win_count + 1'b1;
            win_sum   = win_sum + smp;
            if (smp > burst_thr) win_over = win_over + 1'b1;
         end
      end
      ACT_TICK: begin
         if (dwell_active) begin
            if (win_ms_elapsed != WINEL_MAX) win_ms_elapsed = win_ms_elapsed + 1'b1;
            if (dwell_ms_elapsed != TOTAL_MAX) dwell_ms_elapsed = dwell_ms_elapsed + 1'b1;
            win_len = cfg_window_ms;
            if (win_len < WIN_MIN) win_len = WIN_MIN;
            if (win_len > WIN_MAX) win_len = WIN_MAX;
            dur_len = cfg_duration_s;
            if (dur_len < DUR_MIN) dur_len = DUR_MIN;
            if (dur_len > DUR_MAX) dur_len = DUR_MAX;
            closing = (win_ms_elapsed >= win_len) && (win_count != 0);
            ending  = longint'(dwell_ms_elapsed) >= longint'(dur_len) * 1000;
            if (closing) begin
               cnt  = longint'(win_count);
               mag  = (win_sum < 0) ? -longint'(win_sum) : longint'(win_sum);
               // round half away from zero on the magnitude
               quo  = (mag * 2 + cnt) / (2 * cnt);
               avg  = (win_sum < 0) ? -quo : quo;
               duty = longint'(win_over) * 1000 / cnt;
               rep.kind           = KIND_REPORT;
               rep.sample_count   = win_count;
               rep.average        = avg[11:0];
               rep.maximum        = win_max;
               rep.minimum        = win_min;
               rep.over_count     = win_over;
               rep.duty_permille  = duty[9:0];
               rep.threshold_used = burst_thr;
               rep.last           = ~ending;
               pending_reports.push_back(rep);
               // adapt the burst threshold, clamped to the 12 bit range
               next_thr = longint'(win_min) + longint'(cfg_delta);
               if (next_thr > 2047) next_thr = 2047;
               if (next_thr < -2048) next_thr = -2048;
               burst_thr = next_thr[11:0];
               open_window();
            end
            if (ending) begin
               fin.kind     = KIND_DONE;
               fin.last     = 1'b1;
               pending_reports.push_back(fin);
               dwell_active = 1'b0;
            end
         end
      end
      default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic signed [63:0] got,
                                input logic signed [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Compare each accepted result with the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            flag_mismatch("result with nothing pending, kind", rsp_data.kind, -1);
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_data.kind !== oldest_report.kind)
               flag_mismatch("kind", rsp_data.kind, oldest_report.kind);
            if (rsp_data.sample_count !== oldest_report.sample_count)
               flag_mismatch("sample_count", rsp_data.sample_count,
                             oldest_report.sample_count);
            if (rsp_data.average !== oldest_report.average)
               flag_mismatch("average", $signed(rsp_data.average),
                             $signed(oldest_report.average));
            if (rsp_data.maximum !== oldest_report.maximum)
               flag_mismatch("maximum", $signed(rsp_data.maximum),
                             $signed(oldest_report.maximum));
            if (rsp_data.minimum !== oldest_report.minimum)
               flag_mismatch("minimum", $signed(rsp_data.minimum),
                             $signed(oldest_report.minimum));
            if (rsp_data.over_count !== oldest_report.over_count)
               flag_mismatch("over_count", rsp_data.over_count, oldest_report.over_count);
            if (rsp_data.duty_permille !== oldest_report.duty_permille)
               flag_mismatch("duty_permille", rsp_data.duty_permille,
                             oldest_report.duty_permille);
            if (rsp_data.threshold_used !== oldest_report.threshold_used)
               flag_mismatch("threshold_used", $signed(rsp_data.threshold_used),
                             $signed(oldest_report.threshold_used));
            if (rsp_data.last !== oldest_report.last)
               flag_mismatch("last", rsp_data.last, oldest_report.last);
         end
      end
   end

   // Stall the result channel at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // End the run when no channel has moved an item for too long; this also
   // catches predicted items that never arrive
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Present one item, hold it until accepted, then predict what it causes.
   // Valid is left high afterwards, so back-to-back items keep it asserted.
   task automatic send_item(input act_type act, input logic [11:0] rssi);
      req_type item;
      item.action = act;
      item.rssi   = rssi;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      compute_window_results(item);
   endtask

   // Millisecond ticks; rssi is ignored on them, so keep it random
   task automatic send_ticks(input int n);
      repeat (n) send_item(ACT_TICK, 12'($urandom));
   endtask

   // Mostly samples from a band around a wandering center, some anywhere,
   // some at the two ends of the field
   function automatic logic [11:0] pick_rssi();
      int v;
      case ($urandom_range(9))
      0: v = int'($urandom_range(4095)) - 2048;
      1: v = $urandom_range(1) ? 2047 : -2048;
      default: v = band_center + int'($urandom_range(400)) - 200;
      endcase
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return v[11:0];
   endfunction

   // Hold the sender until everything predicted has come back, then let the
   // back end finish any quiet work
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; valid stays high for the next write
   task automatic write_register(input csr_index_type idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
      CSR_WINDOW_MS:       cfg_window_ms  = value[15:0];
      CSR_DURATION_S:      cfg_duration_s = value;
      CSR_THRESHOLD_DELTA: cfg_delta      = value[8:0];
      CSR_FIRST_THRESHOLD: cfg_first_thr  = value[11:0];
      endcase
   endtask

   // Drain the block, then write all four registers
   task automatic load_settings(input logic [15:0] window_ms, input logic [16:0] duration_s,
                                input logic [8:0] delta, input logic [11:0] first_thr);
      drain_results();
      write_register(CSR_WINDOW_MS, 17'(window_ms));
      write_register(CSR_DURATION_S, duration_s);
      write_register(CSR_THRESHOLD_DELTA, 17'(delta));
      write_register(CSR_FIRST_THRESHOLD, 17'(first_thr));
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Before any start everything is dropped; then run a full dwell on the
   // register values left by reset (1000 ms windows, 60 s dwell)
   task automatic test_idle_and_defaults();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(ACT_SAMPLE, 12'h123);
      send_ticks(3);
      send_item(ACT_NONE, 12'h7FF);
      send_item(ACT_START, 12'($urandom));
      // threshold -1000: equal is not over, one above is
      send_item(ACT_SAMPLE, -12'sd1000);
      send_item(ACT_SAMPLE, -12'sd999);
      send_item(ACT_SAMPLE, 12'sd2000);
      send_item(ACT_SAMPLE, -12'sd2000);
      send_ticks(1000);
      // next threshold is -2000 + 100
      send_item(ACT_SAMPLE, -12'sd1900);
      send_item(ACT_SAMPLE, -12'sd1899);
      // empty windows stay silent until the dwell ends on its own
      send_ticks(59000);
   endtask

   // Short windows: extremes, rounding ties, threshold adaption and its
   // clamp, and a window that closes on the very tick the dwell ends
   task automatic test_window_statistics();
      load_settings(16'd0, 17'd0, 9'd500, 12'h800);
      send_item(ACT_START, 12'($urandom));
      // -2048 equals the first threshold and so does not count as over
      send_item(ACT_SAMPLE, 12'h800);
      send_item(ACT_SAMPLE, 12'sd2047);
      send_item(ACT_SAMPLE, -12'sd1);
      send_item(ACT_NONE, 12'($urandom));
      send_item(ACT_SAMPLE, -12'sd2);
      send_ticks(100);
      // a lone 2047 pushes the next threshold past the top, so it clamps
      send_item(ACT_SAMPLE, 12'sd2047);
      send_ticks(100);
      // 1.5 rounds up to 2
      send_item(ACT_SAMPLE, 12'sd1);
      send_item(ACT_SAMPLE, 12'sd2);
      send_ticks(100);
      // -1.5 rounds down to -2
      send_item(ACT_SAMPLE, -12'sd1);
      send_item(ACT_SAMPLE, -12'sd2);
      send_ticks(100);
      // the tenth window closes on the tick that ends the 1 s dwell
      repeat (6) begin
         send_item(ACT_SAMPLE, pick_rssi());
         send_ticks(100);
      end
      // idle again: both dropped
      send_item(ACT_SAMPLE, 12'sd55);
      send_ticks(2);
   endtask

   // A start in mid dwell clears everything; an overdue empty window
   // reports on the first tick after a sample arrives
   task automatic test_restart_and_empty_window();
      load_settings(16'd250, 17'd1, 9'd0, 12'sd2047);
      send_item(ACT_START, 12'($urandom));
      send_item(ACT_SAMPLE, 12'sd100);
      send_item(ACT_SAMPLE, -12'sd100);
      send_ticks(50);
      send_item(ACT_START, 12'($urandom));
      send_item(ACT_SAMPLE, 12'sd5);
      send_ticks(250);
      send_ticks(300);
      send_item(ACT_SAMPLE, 12'sd6);
      send_ticks(1);
      send_ticks(449);
   endtask

   // Longest window, then a window timer left to saturate while empty
   task automatic test_timer_saturation();
      load_settings(16'hFFFF, 17'h1FFFF, 9'd0, 12'd0);
      send_item(ACT_START, 12'($urandom));
      send_item(ACT_SAMPLE, 12'sd7);
      send_ticks(60000);
      // past 65535 the timer must hold, not wrap
      send_ticks(65600);
      send_item(ACT_SAMPLE, -12'sd3);
      send_ticks(1);
   endtask

   // Random traffic: mostly well-formed dwells of ticks and samples, with
   // rare restarts, ignored codes, and noise while idle
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [15:0] window_ms,
                                      input logic [16:0] duration_s,
                                      input logic [8:0] delta, input logic [11:0] first_thr,
                                      input int item_goal, input int report_goal);
      int      live_items;
      int      results_at_start;
      int      pick;
      act_type act;
      load_settings(window_ms, duration_s, delta, first_thr);
      send_idle_pct    = idle_pct;
      rsp_stall_pct    = stall_pct;
      live_items       = 0;
      results_at_start = results_seen;
      while (live_items < item_goal || results_seen - results_at_start < report_goal) begin
         if ($urandom_range(63) == 0) band_center = int'($urandom_range(4000)) - 2000;
         // now and then hold the sender until everything is back
         if ($urandom_range(499) == 0) drain_results();
         pick = $urandom_range(999);
         if (!dwell_active)
            act = (pick < 800) ? ACT_START : (pick < 900) ? ACT_TICK :
                  (pick < 950) ? ACT_SAMPLE : ACT_NONE;
         else if (pick < 2)
            act = ACT_START;
         else if (pick < 25)
            act = ACT_NONE;
         else if (pick < 300)
            act = ACT_SAMPLE;
         else
            act = ACT_TICK;
         if (act == ACT_START || (dwell_active && act != ACT_NONE)) live_items++;
         send_item(act, (act == ACT_SAMPLE) ? pick_rssi() : 12'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_defaults();
      test_window_statistics();
      test_restart_and_empty_window();
      test_timer_saturation();
      // no idling, extreme settings
      test_random_traffic(0, 0, 16'd100, 17'd1, 9'd511, 12'h800, 260, 12);
      // sender idle most cycles
      test_random_traffic(83, 0, 16'($urandom_range(180)), 17'($urandom_range(2)),
                          9'($urandom), 12'($urandom), 260, 12);
      // receiver stalling most cycles
      test_random_traffic(0, 83, 16'($urandom_range(180)), 17'($urandom_range(2)),
                          9'($urandom), 12'($urandom), 260, 12);
      // both sides idling, opposite extremes
      test_random_traffic(26, 26, 16'd99, 17'd2, 9'd0, 12'sd2047, 260, 12);
      drain_results();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
